>>> hw/rtl/i2cm_pkg.sv
// shared types and constants for the i2c master bit sequencer
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_W = 5;
   localparam int BYTE_BITS = 8;
   localparam int BIT_W = 3;
   localparam int PHASE_W = 2;

   localparam logic [STEP_W-1:0] START_LAST = 5'd3;
   localparam logic [STEP_W-1:0] STOP_LAST = 5'd2;
   localparam logic [STEP_W-1:0] RECV_LAST = 5'd16;
   localparam logic [STEP_W-1:0] ACK_LAST = 5'd2;
   localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;
   localparam logic [PHASE_W-1:0] PHASE_SDA = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_HIGH = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_LOW = 2'd2;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_SEND  = 3'd2,
      OP_RECV  = 3'd3,
      OP_SACK  = 3'd4,
      OP_RACK  = 3'd5
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic [7:0] line_bits;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } q_status_type;

endpackage

>>> hw/rtl/i2cm_front.sv
// command intake: classifies transfers and drops unused command codes
`timescale 1ns / 1ps

module i2cm_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_func,
   input  logic [7:0]            req_tx_byte,
   input  logic                  req_ack_to_send,
   input  logic [7:0]            req_line_bits,
   input  i2cm_pkg::q_status_type q_status,
   output logic                  push,
   output i2cm_pkg::cmd_type     push_cmd
);
   import i2cm_pkg::*;

   logic known_op;

   always_comb begin
      known_op = req_func inside {[OP_START:OP_RACK]};
   end

   assign req_stall = q_status.full;
   assign push = req_valid && !q_status.full && known_op;

   always_comb begin
      push_cmd.op = op_type'(req_func);
      push_cmd.tx_byte = req_tx_byte;
      push_cmd.ack_to_send = req_ack_to_send;
      push_cmd.line_bits = req_line_bits;
   end

endmodule

>>> hw/rtl/i2cm_queue.sv
// short command queue between intake and sequencer
`timescale 1ns / 1ps

module i2cm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  i2cm_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output i2cm_pkg::q_status_type q_status,
   output i2cm_pkg::cmd_type      head_cmd
);
   import i2cm_pkg::*;

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd = mem_ff[rd_ptr_ff];
   assign q_status.full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.head_valid = (count_ff != '0);

endmodule

>>> hw/rtl/i2cm_back.sv
// pin step sequencer with registered result stage
`timescale 1ns / 1ps

module i2cm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cm_pkg::q_status_type q_status,
   input  i2cm_pkg::cmd_type      head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_scl_level,
   output logic                   rsp_sda_level,
   output logic [7:0]             rsp_rx_byte,
   output logic                   rsp_rx_ack,
   output logic                   rsp_last_step
);
   import i2cm_pkg::*;

   logic               scl_drive_ff, scl_drive_in;
   logic               sda_drive_ff, sda_drive_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_scl_ff, rsp_sda_ff, rsp_rx_ack_ff, rsp_last_ff;
   logic [7:0]         rsp_rx_byte_ff;

   logic       advance;
   logic       is_last;
   logic [7:0] rx_byte;
   logic       rx_ack;

   assign advance = q_status.head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop = advance && is_last;

   // one pin step of the head command
   always_comb begin
      scl_drive_in = scl_drive_ff;
      sda_drive_in = sda_drive_ff;
      is_last = 1'b0;
      rx_byte = '0;
      rx_ack = 1'b0;
      case (head_cmd.op)
         OP_START: begin
            case (step_ff)
               5'd0:    sda_drive_in = 1'b1;
               5'd1:    scl_drive_in = 1'b1;
               5'd2:    sda_drive_in = 1'b0;
               default: scl_drive_in = 1'b0;
            endcase
            is_last = (step_ff == START_LAST);
         end
         OP_STOP: begin
            case (step_ff)
               5'd0:    sda_drive_in = 1'b0;
               5'd1:    scl_drive_in = 1'b1;
               default: sda_drive_in = 1'b1;
            endcase
            is_last = (step_ff == STOP_LAST);
         end
         OP_SEND: begin
            case (phase_ff)
               PHASE_SDA:  sda_drive_in = head_cmd.tx_byte[BIT_LAST - bit_ff];
               PHASE_HIGH: scl_drive_in = 1'b1;
               default:    scl_drive_in = 1'b0;
            endcase
            is_last = (bit_ff == BIT_LAST) && (phase_ff == PHASE_LOW);
         end
         OP_RECV: begin
            if (step_ff == '0) begin
               sda_drive_in = 1'b1;
            end else begin
               scl_drive_in = step_ff[0];
            end
            is_last = (step_ff == RECV_LAST);
            rx_byte = is_last ? head_cmd.line_bits : '0;
         end
         OP_SACK, OP_RACK: begin
            case (step_ff)
               5'd0:    sda_drive_in = (head_cmd.op == OP_SACK) ? head_cmd.ack_to_send : 1'b1;
               5'd1:    scl_drive_in = 1'b1;
               default: scl_drive_in = 1'b0;
            endcase
            is_last = (step_ff == ACK_LAST);
            rx_ack = is_last && (head_cmd.op == OP_RACK) && head_cmd.line_bits[7];
         end
         default: begin
            is_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      bit_in = bit_ff;
      phase_in = phase_ff;
      if (advance) begin
         if (is_last) begin
            step_in = '0;
            bit_in = '0;
            phase_in = PHASE_SDA;
         end else begin
            step_in = step_ff + 1'b1;
            if (phase_ff == PHASE_LOW) begin
               phase_in = PHASE_SDA;
               bit_in = bit_ff + 1'b1;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_drive_ff <= 1'b1;
         sda_drive_ff <= 1'b1;
         step_ff <= '0;
         bit_ff <= '0;
         phase_ff <= PHASE_SDA;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            scl_drive_ff <= scl_drive_in;
            sda_drive_ff <= sda_drive_in;
         end
         step_ff <= step_in;
         bit_ff <= bit_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_scl_ff <= scl_drive_in;
         rsp_sda_ff <= sda_drive_in;
         rsp_rx_byte_ff <= rx_byte;
         rsp_rx_ack_ff <= rx_ack;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_scl_level = rsp_scl_ff;
   assign rsp_sda_level = rsp_sda_ff;
   assign rsp_rx_byte = rsp_rx_byte_ff;
   assign rsp_rx_ack = rsp_rx_ack_ff;
   assign rsp_last_step = rsp_last_ff;

`ifndef SYNTHESIS
   a_rx_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_step) |-> (rsp_rx_byte == '0) && !rsp_rx_ack)
      else $error("receive data outside last step");

   a_stop_releases: assert property (@(posedge clock) disable iff (reset)
      (advance && is_last && head_cmd.op == OP_STOP) |=> scl_drive_ff && sda_drive_ff)
      else $error("stop did not release bus");

   a_start_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && is_last && head_cmd.op == OP_START) |=> !scl_drive_ff && !sda_drive_ff)
      else $error("start did not leave both lines low");

   a_counters_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (step_ff == '0) && (bit_ff == '0) && (phase_ff == PHASE_SDA))
      else $error("step counters not cleared after command");
`endif

endmodule

>>> hw/rtl/i2c_master_bit_sequencer_core.sv
// i2c master bit sequencer top level
// the first pin step of a command passes the command queue, then the registered result stage
// throughput: one pin step per cycle unless rsp_stall holds the result stage; a two-entry
// command queue takes the next command while the sequencer steps through the current one
// reset: synchronous, both lines released, queue and result stage empty
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_func,
   input  logic [7:0] req_tx_byte,
   input  logic       req_ack_to_send,
   input  logic [7:0] req_line_bits,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_rx_ack,
   output logic       rsp_last_step
);
   import i2cm_pkg::*;

   q_status_type q_status;
   cmd_type      push_cmd;
   cmd_type      head_cmd;
   logic         push;
   logic         pop;

   i2cm_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_tx_byte     (req_tx_byte),
      .req_ack_to_send (req_ack_to_send),
      .req_line_bits   (req_line_bits),
      .q_status        (q_status),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   i2cm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head_cmd (head_cmd)
   );

   i2cm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl_level (rsp_scl_level),
      .rsp_sda_level (rsp_sda_level),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_rx_ack    (rsp_rx_ack),
      .rsp_last_step (rsp_last_step)
   );

endmodule

>>> verif/i2c_master_bit_sequencer_core_test.sv
// self-checking testbench for the i2c master bit sequencer core
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_test;
   import i2cm_pkg::*;

   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;
   localparam int RANDOM_CMDS = 360;
   localparam int LIMIT_CYCLES = 1500000;
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic [7:0] line_bits;
      logic       typed;
      logic [7:0] typed_rx_byte;
      logic       typed_rx_ack;
   } cmd_row_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] rx_byte;
      logic       rx_ack;
      logic       last_step;
   } pin_step_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_func = 3'd0;
   logic [7:0] req_tx_byte = 8'd0;
   logic       req_ack_to_send = 1'b0;
   logic [7:0] req_line_bits = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_level;
   logic [7:0] rsp_rx_byte;
   logic       rsp_rx_ack;
   logic       rsp_last_step;

   pin_step_type pin_steps_q [$];
   cmd_row_type  directed_rows [$];
   logic         scl_now;
   logic         sda_now;
   int           errors = 0;
   int           step_count = 0;
   int           cycles = 0;
   int           random_cmds = 0;
   bit           quiet_req = 0;
   bit           quiet_rsp = 0;
   int           stall_left = 0;

   i2c_master_bit_sequencer_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_tx_byte     (req_tx_byte),
      .req_ack_to_send (req_ack_to_send),
      .req_line_bits   (req_line_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_rx_ack      (rsp_rx_ack),
      .rsp_last_step   (rsp_last_step)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic push_step(input logic last, input logic [7:0] rxb, input logic rxa);
      pin_step_type s;
      s.scl = scl_now;
      s.sda = sda_now;
      s.rx_byte = rxb;
      s.rx_ack = rxa;
      s.last_step = last;
      pin_steps_q.push_back(s);
   endtask

   // pin steps that one command drives onto the bus
   task automatic predict_pin_steps(input cmd_row_type row);
      logic [7:0] rxb;
      logic       rxa;
      rxb = row.typed ? row.typed_rx_byte : row.line_bits;
      rxa = row.typed ? row.typed_rx_ack : row.line_bits[7];
      case (row.func)
         OP_START: begin
            sda_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
            scl_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
            sda_now = 1'b0; push_step(1'b0, 8'd0, 1'b0);
            scl_now = 1'b0; push_step(1'b1, 8'd0, 1'b0);
         end
         OP_STOP: begin
            sda_now = 1'b0; push_step(1'b0, 8'd0, 1'b0);
            scl_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
            sda_now = 1'b1; push_step(1'b1, 8'd0, 1'b0);
         end
         OP_SEND: begin
            for (int i = 7; i >= 0; i--) begin
               sda_now = row.tx_byte[i]; push_step(1'b0, 8'd0, 1'b0);
               scl_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
               scl_now = 1'b0; push_step(i == 0, 8'd0, 1'b0);
            end
         end
         OP_RECV: begin
            sda_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
            for (int i = 7; i >= 0; i--) begin
               scl_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
               scl_now = 1'b0; push_step(i == 0, (i == 0) ? rxb : 8'd0, 1'b0);
            end
         end
         OP_SACK: begin
            sda_now = row.ack_to_send; push_step(1'b0, 8'd0, 1'b0);
            scl_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
            scl_now = 1'b0; push_step(1'b1, 8'd0, 1'b0);
         end
         OP_RACK: begin
            sda_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
            scl_now = 1'b1; push_step(1'b0, 8'd0, 1'b0);
            scl_now = 1'b0; push_step(1'b1, 8'd0, rxa);
         end
         default: begin
         end
      endcase
   endtask

   function automatic cmd_row_type cmd_row(input logic [2:0] func, input logic [7:0] tx,
                                           input logic ack, input logic [7:0] line);
      cmd_row_type r;
      r.func = func;
      r.tx_byte = tx;
      r.ack_to_send = ack;
      r.line_bits = line;
      r.typed = 1'b0;
      r.typed_rx_byte = 8'd0;
      r.typed_rx_ack = 1'b0;
      return r;
   endfunction

   task automatic add_row(input logic [2:0] func, input logic [7:0] tx, input logic ack,
                          input logic [7:0] line, input logic typed, input logic [7:0] rxb,
                          input logic rxa);
      cmd_row_type r;
      r = cmd_row(func, tx, ack, line);
      r.typed = typed;
      r.typed_rx_byte = rxb;
      r.typed_rx_ack = rxa;
      directed_rows.push_back(r);
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet_req) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic issue_cmd(input cmd_row_type row);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= row.func;
      req_tx_byte <= row.tx_byte;
      req_ack_to_send <= row.ack_to_send;
      req_line_bits <= row.line_bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pin_steps(row);
      if (row.func <= OP_RACK) random_cmds++;
   endtask

   task automatic drain_steps();
      req_valid <= 1'b0;
      do @(posedge clock); while (pin_steps_q.size() != 0);
   endtask

   // one bus transaction: start, address, data bytes with acks, and usually a stop
   task automatic run_transaction();
      bit         rd;
      int         nbytes;
      logic [7:0] addr;
      logic [7:0] ln;
      rd = rand_bit();
      nbytes = $urandom_range(1, 4);
      addr = rand_byte();
      addr[0] = rd;
      issue_cmd(cmd_row(OP_START, rand_byte(), rand_bit(), rand_byte()));
      issue_cmd(cmd_row(OP_SEND, addr, rand_bit(), rand_byte()));
      ln = rand_byte();
      if ($urandom_range(0, 6) != 0) ln[7] = 1'b0;
      issue_cmd(cmd_row(OP_RACK, rand_byte(), rand_bit(), ln));
      for (int i = 0; i < nbytes; i++) begin
         if (rd) begin
            issue_cmd(cmd_row(OP_RECV, rand_byte(), rand_bit(), rand_byte()));
            issue_cmd(cmd_row(OP_SACK, rand_byte(),
                              (i == nbytes - 1) ^ ($urandom_range(0, 9) == 0),
                              rand_byte()));
         end else begin
            issue_cmd(cmd_row(OP_SEND, rand_byte(), rand_bit(), rand_byte()));
            ln = rand_byte();
            if ($urandom_range(0, 4) != 0) ln[7] = 1'b0;
            issue_cmd(cmd_row(OP_RACK, rand_byte(), rand_bit(), ln));
         end
      end
      if ($urandom_range(0, 4) != 0)
         issue_cmd(cmd_row(OP_STOP, rand_byte(), rand_bit(), rand_byte()));
   endtask

   initial begin
      bit paused;
      paused = 0;
      scl_now = 1'b1;
      sda_now = 1'b1;
      add_row(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_SEND, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_RACK, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0);
      add_row(OP_SEND, 8'hFF, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0);
      add_row(OP_RACK, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'h00, 1'b1);
      add_row(OP_SEND, 8'hA5, 1'b0, 8'h5A, 1'b0, 8'h00, 1'b0);
      add_row(OP_RACK, 8'h00, 1'b0, 8'h7F, 1'b1, 8'h00, 1'b0);
      add_row(OP_RECV, 8'hFF, 1'b1, 8'h00, 1'b1, 8'h00, 1'b0);
      add_row(OP_SACK, 8'h00, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0);
      add_row(OP_RECV, 8'h00, 1'b0, 8'hFF, 1'b1, 8'hFF, 1'b0);
      add_row(OP_SACK, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_RECV, 8'h3C, 1'b0, 8'h5A, 1'b0, 8'h00, 1'b0);
      add_row(FUNC_SPARE_A, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'h00, 1'b0);
      add_row(FUNC_SPARE_B, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0);
      add_row(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_STOP, 8'hFF, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0);
      add_row(OP_START, 8'hFF, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0);
      add_row(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_SACK, 8'hFF, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0);
      add_row(OP_RACK, 8'h00, 1'b0, 8'h80, 1'b1, 8'h00, 1'b1);
      add_row(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) issue_cmd(directed_rows[i]);
      drain_steps();
      random_cmds = 0;
      while (random_cmds < RANDOM_CMDS) begin
         quiet_req = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0)
            issue_cmd(cmd_row(3'($urandom_range(0, 7)), rand_byte(), rand_bit(),
                              rand_byte()));
         else
            run_transaction();
         if (!paused && random_cmds >= RANDOM_CMDS / 2) begin
            paused = 1;
            drain_steps();
         end
      end
      drain_steps();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("** i2c_master_bit_sequencer_core: PASSED **");
      else
         $display("** i2c_master_bit_sequencer_core: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      pin_step_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("** i2c_master_bit_sequencer_core: FAILED **");
         $finish;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pin_steps_q.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("unexpected pin step %0d: scl %b sda %b rx %h ack %b last %b",
                           step_count, rsp_scl_level, rsp_sda_level, rsp_rx_byte,
                           rsp_rx_ack, rsp_last_step);
               errors++;
            end else begin
               e = pin_steps_q.pop_front();
               if (rsp_scl_level !== e.scl || rsp_sda_level !== e.sda ||
                   rsp_rx_byte !== e.rx_byte || rsp_rx_ack !== e.rx_ack ||
                   rsp_last_step !== e.last_step) begin
                  if (errors < MAX_REPORTS)
                     $display("pin step %0d: exp %b %b %h %b %b, got %b %b %h %b %b",
                              step_count, e.scl, e.sda, e.rx_byte, e.rx_ack, e.last_step,
                              rsp_scl_level, rsp_sda_level, rsp_rx_byte, rsp_rx_ack,
                              rsp_last_step);
                  errors++;
               end
            end
            step_count++;
         end
         if (cycles % 400 == 0) quiet_rsp = ($urandom_range(0, 3) == 0);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_rsp && $urandom_range(0, 9) < 3) begin
            stall_left = ($urandom_range(0, 49) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule
